FILE: src/rie_pkg.sv
// shared types, codes and constants of the redcode instruction executor
package rie_pkg;

  localparam int CORE_DEPTH = 8192;
  localparam int AW         = $clog2(CORE_DEPTH);
  localparam int MAX_TASKS  = 64;

  localparam logic [13:0] LOADER_MARK   = 14'd8192;
  localparam logic [1:0]  CLEARED_OWNER = 2'd3;
  localparam logic [13:0] SIZE_MAX      = 14'(CORE_DEPTH);
  localparam logic [6:0]  TASKS_MAX     = 7'(MAX_TASKS);

  // request codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // instruction codes
  localparam logic [3:0] I_DAT = 4'd0;
  localparam logic [3:0] I_MOV = 4'd1;
  localparam logic [3:0] I_ADD = 4'd2;
  localparam logic [3:0] I_SUB = 4'd3;
  localparam logic [3:0] I_JMP = 4'd4;
  localparam logic [3:0] I_JMZ = 4'd5;
  localparam logic [3:0] I_JMN = 4'd6;
  localparam logic [3:0] I_DJN = 4'd7;
  localparam logic [3:0] I_CMP = 4'd8;
  localparam logic [3:0] I_SPL = 4'd9;

  // addressing modes
  localparam logic [1:0] M_IMM  = 2'd0;
  localparam logic [1:0] M_DIR  = 2'd1;
  localparam logic [1:0] M_IND  = 2'd2;
  localparam logic [1:0] M_ADEC = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CORE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_SPLIT_LIMIT = 2'd1;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  mode_a;
    logic [1:0]  mode_b;
    logic [15:0] a_val;
    logic [15:0] b_val;
    logic [1:0]  owner;
    logic [13:0] writer;
  } word_t;

  typedef struct packed {
    logic [AW-1:0] next_pc;
    logic          task_died;
    logic          spawn_valid;
    logic [AW-1:0] spawn_addr;
    logic          split_refused;
    word_t         word;
  } result_t;

endpackage

FILE: src/rie_if.sv
// handshake channels of the redcode instruction executor
interface rie_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [12:0] address;
  logic        player;
  logic [6:0]  task_count;
  logic [3:0]  opcode_in;
  logic [1:0]  mode_a_in;
  logic [1:0]  mode_b_in;
  logic signed [15:0] a_in;
  logic signed [15:0] b_in;
  logic [13:0] clear_writer;
  modport source (output valid, op, address, player, task_count, opcode_in, mode_a_in,
                  mode_b_in, a_in, b_in, clear_writer, input ready);
  modport sink (input valid, op, address, player, task_count, opcode_in, mode_a_in,
                mode_b_in, a_in, b_in, clear_writer, output ready);
endinterface

interface rie_res_if;
  logic        valid;
  logic        ready;
  logic [12:0] next_pc;
  logic        task_died;
  logic        spawn_valid;
  logic [12:0] spawn_addr;
  logic        split_refused;
  logic [3:0]  word_opcode;
  logic [1:0]  word_mode_a;
  logic [1:0]  word_mode_b;
  logic signed [15:0] word_a;
  logic signed [15:0] word_b;
  logic [1:0]  word_owner;
  logic [13:0] word_writer;
  modport source (output valid, next_pc, task_died, spawn_valid, spawn_addr, split_refused,
                  word_opcode, word_mode_a, word_mode_b, word_a, word_b, word_owner,
                  word_writer, input ready);
  modport sink (input valid, next_pc, task_died, spawn_valid, spawn_addr, split_refused,
                word_opcode, word_mode_a, word_mode_b, word_a, word_b, word_owner,
                word_writer, output ready);
endinterface

interface rie_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/redcode_instruction_executor.sv
// top level: request sequencer of the redcode instruction executor
//
// usage
// - in_ch carries one request word: load, execute, read or clear a core location
// - out_ch returns exactly one result word per request, in request order
// - cfg_ch writes core_size (index 0) and split_limit (index 1); always ready;
//   the user writes it only while the block is idle, which the block does not enforce
// - every address is first wrapped modulo core_size by a bit-serial unit,
//   which sets the pace of the whole block
// - load, clear: wrap, then write; read: wrap, then read the registered word
// - execute: paced by the core memory's single port and up to six serial
//   wraps (pc, each operand's pointer and its indirection, next pc)
// - one request is in flight at a time; in_ch is ready when the sequencer idles
// - a finished result waits in the output register, so the next request may be
//   taken while the receiver stalls; a second result then waits for the slot
// - reset restores core_size 8000 and split_limit 64 and empties the output;
//   core contents stay undefined until loaded or cleared, no clearing pass
module redcode_instruction_executor (
  input  logic      clk,
  input  logic      rst_n,
  rie_req_if.sink   in_ch,
  rie_res_if.source out_ch,
  rie_cfg_if.sink   cfg_ch
);

  localparam int AW = rie_pkg::AW;

  typedef enum logic [3:0] {
    S_IDLE, S_AW, S_RDW, S_PCW, S_TW, S_TRD, S_EW, S_NEXTOP, S_E1, S_E2, S_EXE, S_NW,
    S_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic [13:0] core_size_r;
  logic [6:0]  split_limit_r;
  logic [13:0] size_eff;
  logic [6:0]  lim_eff;

  // latched request word
  logic [1:0]     op_r;
  logic           player_r;
  logic [6:0]     tasks_r;
  rie_pkg::word_t ld_r;
  logic [13:0]    clr_wr_r;

  // execute context
  logic [AW-1:0]  pc_r, t_r, ea1_r, ea2_r;
  logic           opnd_r;
  rie_pkg::word_t pcw_r, w1_r, w2_r;
  rie_pkg::result_t res_r;

  // output slot
  logic             out_valid_r;
  rie_pkg::result_t out_r;

  // memory port
  logic [AW-1:0]  m_addr;
  logic           m_we, m_re;
  rie_pkg::word_t m_wdata, m_rdata;

  // wrap unit
  logic              w_start, w_done;
  logic signed [17:0] w_x;
  logic [AW-1:0]     w_res;

  // operand decode at the pc word
  logic [1:0]  cur_mode;
  logic [15:0] cur_val;
  logic [15:0] dec_b;
  logic        imm;
  logic [15:0] src_val;
  logic        same;

  always_comb begin
    if (core_size_r == '0)          size_eff = 14'd1;
    else if (core_size_r > rie_pkg::SIZE_MAX) size_eff = rie_pkg::SIZE_MAX;
    else                            size_eff = core_size_r;
    lim_eff = (split_limit_r > rie_pkg::TASKS_MAX) ? rie_pkg::TASKS_MAX : split_limit_r;
  end

  assign cur_mode = opnd_r ? m_rdata.mode_b : m_rdata.mode_a;
  assign cur_val  = opnd_r ? m_rdata.b_val  : m_rdata.a_val;
  assign dec_b    = m_rdata.b_val - 16'd1;
  assign imm      = (pcw_r.mode_a == rie_pkg::M_IMM);
  assign src_val  = imm ? w1_r.a_val : w1_r.b_val;
  assign same     = imm ? (w1_r.a_val == w2_r.b_val)
                        : (w1_r.opcode == w2_r.opcode && w1_r.mode_a == w2_r.mode_a &&
                           w1_r.mode_b == w2_r.mode_b && w1_r.a_val == w2_r.a_val &&
                           w1_r.b_val == w2_r.b_val);

  rie_core_mem u_mem (
    .clk   (clk),
    .addr  (m_addr),
    .we    (m_we),
    .re    (m_re),
    .wdata (m_wdata),
    .rdata (m_rdata)
  );

  rie_wrap u_wrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (w_start),
    .x      (w_x),
    .n      (size_eff),
    .done   (w_done),
    .result (w_res)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // memory port, wrap launches and the next pointer mark
  always_comb begin
    m_addr  = pc_r;
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_wdata = ld_r;
    w_start = 1'b0;
    w_x     = $signed({5'b0, in_ch.address});
    unique case (state_r)
      S_IDLE: w_start = in_ch.valid;
      S_AW: begin
        m_addr = w_res;
        if (w_done) begin
          unique case (op_r)
            rie_pkg::OP_LOAD: m_we = 1'b1;
            rie_pkg::OP_CLEAR: begin
              m_we    = 1'b1;
              m_wdata = '{opcode: rie_pkg::I_DAT, mode_a: rie_pkg::M_IMM,
                          mode_b: rie_pkg::M_IMM, a_val: '0, b_val: '0,
                          owner: rie_pkg::CLEARED_OWNER, writer: clr_wr_r};
            end
            default: m_re = 1'b1;
          endcase
        end
      end
      S_PCW: begin
        w_start = (cur_mode != rie_pkg::M_IMM);
        w_x     = $signed({5'b0, pc_r}) + $signed({{2{cur_val[15]}}, cur_val});
      end
      S_TW: begin
        m_addr = w_res;
        m_re   = w_done && (cur_mode != rie_pkg::M_DIR);
      end
      S_TRD: begin
        // autodecrement writes the pointer word back with the executor's marks
        m_addr  = t_r;
        m_we    = (opnd_r ? pcw_r.mode_b : pcw_r.mode_a) == rie_pkg::M_ADEC;
        m_wdata = m_rdata;
        m_wdata.b_val  = dec_b;
        m_wdata.owner  = {1'b0, player_r};
        m_wdata.writer = {1'b0, pc_r};
        w_start = 1'b1;
        if ((opnd_r ? pcw_r.mode_b : pcw_r.mode_a) == rie_pkg::M_ADEC)
          w_x = $signed({5'b0, t_r}) + $signed({{2{dec_b[15]}}, dec_b});
        else
          w_x = $signed({5'b0, t_r}) + $signed({{2{m_rdata.b_val[15]}}, m_rdata.b_val});
      end
      S_NEXTOP: begin
        m_re   = 1'b1;
        m_addr = opnd_r ? ea1_r : pc_r;
      end
      S_E1: begin
        m_re   = 1'b1;
        m_addr = ea2_r;
      end
      S_EXE: begin
        m_addr  = ea2_r;
        m_wdata = w2_r;
        m_wdata.owner  = {1'b0, player_r};
        m_wdata.writer = {1'b0, pc_r};
        w_start = 1'b1;
        w_x     = $signed({5'b0, pc_r}) + 18'sd1;
        unique case (pcw_r.opcode)
          rie_pkg::I_MOV: begin
            m_we = 1'b1;
            if (imm) begin
              m_wdata.mode_b = w1_r.mode_a;
              m_wdata.b_val  = w1_r.a_val;
            end else begin
              m_wdata.opcode = w1_r.opcode;
              m_wdata.mode_a = w1_r.mode_a;
              m_wdata.mode_b = w1_r.mode_b;
              m_wdata.a_val  = w1_r.a_val;
              m_wdata.b_val  = w1_r.b_val;
            end
          end
          rie_pkg::I_ADD: begin
            m_we = 1'b1;
            m_wdata.b_val = w2_r.b_val + src_val;
          end
          rie_pkg::I_SUB: begin
            m_we = 1'b1;
            m_wdata.b_val = w2_r.b_val - src_val;
          end
          rie_pkg::I_JMP: w_x = $signed({5'b0, ea1_r});
          rie_pkg::I_JMZ: if (w2_r.b_val == '0) w_x = $signed({5'b0, ea1_r});
          rie_pkg::I_JMN: if (w2_r.b_val != '0) w_x = $signed({5'b0, ea1_r});
          rie_pkg::I_DJN: begin
            m_we = 1'b1;
            m_wdata.b_val = w2_r.b_val - 16'd1;
            if (w2_r.b_val != 16'd1) w_x = $signed({5'b0, ea1_r});
          end
          rie_pkg::I_CMP: if (same) w_x = $signed({5'b0, pc_r}) + 18'sd2;
          rie_pkg::I_SPL: ;
          default: w_start = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      core_size_r   <= 14'd8000;
      split_limit_r <= 7'd64;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == rie_pkg::CFG_CORE_SIZE)   core_size_r   <= cfg_ch.data;
        if (cfg_ch.index == rie_pkg::CFG_SPLIT_LIMIT) split_limit_r <= cfg_ch.data[6:0];
      end
      // the slot empties on a taken word unless a new result refills it
      if (out_valid_r && out_ch.ready && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid) begin
          op_r     <= in_ch.op;
          player_r <= in_ch.player;
          tasks_r  <= in_ch.task_count;
          clr_wr_r <= in_ch.clear_writer;
          ld_r     <= '{opcode: in_ch.opcode_in, mode_a: in_ch.mode_a_in,
                        mode_b: in_ch.mode_b_in, a_val: in_ch.a_in, b_val: in_ch.b_in,
                        owner: {1'b0, in_ch.player}, writer: rie_pkg::LOADER_MARK};
          res_r    <= '0;
          opnd_r   <= 1'b0;
          state_r  <= S_AW;
        end
        S_AW: if (w_done) begin
          pc_r <= w_res;
          unique case (op_r)
            rie_pkg::OP_READ: state_r <= S_RDW;
            rie_pkg::OP_EXEC: state_r <= S_PCW;
            default:          state_r <= S_FIN;
          endcase
        end
        S_RDW: begin
          res_r.word <= m_rdata;
          state_r    <= S_FIN;
        end
        S_PCW: begin
          pcw_r <= m_rdata;
          if (cur_mode == rie_pkg::M_IMM) begin
            if (opnd_r) ea2_r <= pc_r;
            else        ea1_r <= pc_r;
            state_r <= S_NEXTOP;
          end else begin
            state_r <= S_TW;
          end
        end
        S_TW: if (w_done) begin
          t_r <= w_res;
          if ((opnd_r ? pcw_r.mode_b : pcw_r.mode_a) == rie_pkg::M_DIR) begin
            if (opnd_r) ea2_r <= w_res;
            else        ea1_r <= w_res;
            state_r <= S_NEXTOP;
          end else begin
            state_r <= S_TRD;
          end
        end
        S_TRD: state_r <= S_EW;
        S_EW: if (w_done) begin
          if (opnd_r) ea2_r <= w_res;
          else        ea1_r <= w_res;
          state_r <= S_NEXTOP;
        end
        S_NEXTOP: begin
          // operand b rereads the pc word, since operand a may have changed it
          if (opnd_r) begin
            state_r <= S_E1;
          end else begin
            opnd_r  <= 1'b1;
            state_r <= S_PCW;
          end
        end
        S_E1: begin
          w1_r    <= m_rdata;
          state_r <= S_E2;
        end
        S_E2: begin
          w2_r    <= m_rdata;
          state_r <= S_EXE;
        end
        S_EXE: begin
          unique case (pcw_r.opcode)
            rie_pkg::I_MOV, rie_pkg::I_ADD, rie_pkg::I_SUB, rie_pkg::I_JMP,
            rie_pkg::I_JMZ, rie_pkg::I_JMN, rie_pkg::I_DJN, rie_pkg::I_CMP:
              state_r <= S_NW;
            rie_pkg::I_SPL: begin
              if (tasks_r < lim_eff) begin
                res_r.spawn_valid <= 1'b1;
                res_r.spawn_addr  <= ea2_r;
              end else begin
                res_r.split_refused <= 1'b1;
              end
              state_r <= S_NW;
            end
            default: begin
              res_r.task_died <= 1'b1;
              state_r         <= S_FIN;
            end
          endcase
        end
        S_NW: if (w_done) begin
          res_r.next_pc <= w_res;
          state_r       <= S_FIN;
        end
        S_FIN: if (!out_valid_r || out_ch.ready) begin
          out_r       <= res_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_pc       = out_r.next_pc;
  assign out_ch.task_died     = out_r.task_died;
  assign out_ch.spawn_valid   = out_r.spawn_valid;
  assign out_ch.spawn_addr    = out_r.spawn_addr;
  assign out_ch.split_refused = out_r.split_refused;
  assign out_ch.word_opcode   = out_r.word.opcode;
  assign out_ch.word_mode_a   = out_r.word.mode_a;
  assign out_ch.word_mode_b   = out_r.word.mode_b;
  assign out_ch.word_a        = out_r.word.a_val;
  assign out_ch.word_b        = out_r.word.b_val;
  assign out_ch.word_owner    = out_r.word.owner;
  assign out_ch.word_writer   = out_r.word.writer;

endmodule

FILE: src/rie_wrap.sv
// bit-serial modulo unit: wraps a signed sum into 0 .. size-1
module rie_wrap (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [17:0]      x,
  input  logic [13:0]             n,
  output logic                    done,
  output logic [rie_pkg::AW-1:0]  result
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [13:0] n_r, n_nxt;
  logic        neg_r, neg_nxt;
  logic [14:0] sh;
  logic [17:0] absx;
  logic [13:0] fixed;

  always_comb begin
    absx     = x[17] ? 18'(-x) : 18'(x);
    sh       = {rem_r, mag_r[15]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd15;
      mag_nxt  = absx[15:0];
      rem_nxt  = '0;
      n_nxt    = n;
      neg_nxt  = x[17];
    end else if (busy_r) begin
      // one restoring step per cycle
      if (sh >= {1'b0, n_r}) rem_nxt = 14'(sh - {1'b0, n_r});
      else                   rem_nxt = sh[13:0];
      mag_nxt = {mag_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    n_r   <= n_nxt;
    neg_r <= neg_nxt;
  end

  // negative input with a nonzero remainder folds back from the top
  assign fixed  = (neg_r && rem_r != '0) ? 14'(n_r - rem_r) : rem_r;
  assign result = fixed[rie_pkg::AW-1:0];
  assign done   = done_r;

endmodule

FILE: src/rie_core_mem.sv
// single-port core memory with registered read data
module rie_core_mem (
  input  logic                    clk,
  input  logic [rie_pkg::AW-1:0]  addr,
  input  logic                    we,
  input  logic                    re,
  input  rie_pkg::word_t          wdata,
  output rie_pkg::word_t          rdata
);

  rie_pkg::word_t mem [rie_pkg::CORE_DEPTH];
  rie_pkg::word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/redcode_instruction_executor_test.sv
// self-checking testbench of the redcode instruction executor
`timescale 1ns / 100ps

module redcode_instruction_executor_test;

  localparam int CYCLE_LIMIT = 1200000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 700;
  localparam int N_PHASES = 6;
  localparam int RAND_PER_PHASE = 204;
  localparam int WINDOW = 48;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] address;
    logic        player;
    logic [6:0]  task_count;
    logic [3:0]  opcode_in;
    logic [1:0]  mode_a_in;
    logic [1:0]  mode_b_in;
    logic [15:0] a_in;
    logic [15:0] b_in;
    logic [13:0] clear_writer;
  } req_t;

  typedef struct packed {
    req_t             rq;
    rie_pkg::result_t rs;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n;

  rie_req_if req_ch ();
  rie_res_if res_ch ();
  rie_cfg_if cfg_ch ();

  redcode_instruction_executor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow of the core: committed copy plus a scratch copy for trial runs
  rie_pkg::word_t core_mem [rie_pkg::CORE_DEPTH];
  bit    core_known [rie_pkg::CORE_DEPTH];
  rie_pkg::word_t trial_mem [rie_pkg::CORE_DEPTH];
  bit    trial_known [rie_pkg::CORE_DEPTH];
  bit    touch_unknown;

  int core_size_reg = 8000;
  int split_limit_reg = 64;

  pending_t pend_q[$];
  rie_pkg::result_t result_q[$];

  int  err_count = 0;
  int  cycles = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  int  hold_left = 0;
  bit  hold_go = 1'b0;
  bit  quiet = 1'b0;
  int  region_base = 0;
  int  n_op [4];
  int  n_spawn = 0;
  int  n_refused = 0;
  int  n_died = 0;
  int  n_results = 0;

  // ---------------------------------------------------------------- predictor

  function automatic int size_eff();
    if (core_size_reg == 0) return 1;
    if (core_size_reg > rie_pkg::CORE_DEPTH) return rie_pkg::CORE_DEPTH;
    return core_size_reg;
  endfunction

  function automatic int wrap_addr(int x);
    int n, r;
    n = size_eff();
    r = x % n;
    if (r < 0) r += n;
    return r;
  endfunction

  function automatic int sx16(logic [15:0] v);
    return $signed(v);
  endfunction

  // any touch of a location never written makes the trial item unusable
  function automatic rie_pkg::word_t peek(int a);
    if (!trial_known[a]) touch_unknown = 1'b1;
    return trial_mem[a];
  endfunction

  function automatic int operand_addr(int pc, bit is_a, logic pl);
    rie_pkg::word_t w;
    int t, v;
    logic [1:0] m;
    w = peek(pc);
    v = is_a ? sx16(w.a_val) : sx16(w.b_val);
    m = is_a ? w.mode_a : w.mode_b;
    t = wrap_addr(pc + v);
    case (m)
      rie_pkg::M_IMM: return pc;
      rie_pkg::M_DIR: return t;
      rie_pkg::M_IND: begin
        w = peek(t);
        return wrap_addr(sx16(w.b_val) + t);
      end
      default: begin
        // autodecrement: the pointer word is written back and marked
        w = peek(t);
        w.b_val = w.b_val - 16'd1;
        w.owner = {1'b0, pl};
        w.writer = 14'(pc);
        trial_mem[t] = w;
        return wrap_addr(sx16(w.b_val) + t);
      end
    endcase
  endfunction

  function automatic rie_pkg::result_t predict_word(req_t r);
    rie_pkg::result_t rs;
    rie_pkg::word_t s, d, pw;
    int pc, ea1, ea2, nxt, lim;
    logic imm, same;
    rs = '0;
    pc = wrap_addr(int'(r.address));
    case (r.op)
      rie_pkg::OP_LOAD: begin
        trial_mem[pc] = '{opcode: r.opcode_in, mode_a: r.mode_a_in, mode_b: r.mode_b_in,
                          a_val: r.a_in, b_val: r.b_in, owner: {1'b0, r.player},
                          writer: rie_pkg::LOADER_MARK};
        trial_known[pc] = 1'b1;
      end
      rie_pkg::OP_READ: rs.word = peek(pc);
      rie_pkg::OP_CLEAR: begin
        trial_mem[pc] = '{opcode: rie_pkg::I_DAT, mode_a: rie_pkg::M_IMM,
                          mode_b: rie_pkg::M_IMM, a_val: 16'd0, b_val: 16'd0,
                          owner: rie_pkg::CLEARED_OWNER, writer: r.clear_writer};
        trial_known[pc] = 1'b1;
      end
      default: begin
        ea1 = operand_addr(pc, 1'b1, r.player);
        ea2 = operand_addr(pc, 1'b0, r.player);
        pw = peek(pc);
        imm = pw.mode_a == rie_pkg::M_IMM;
        nxt = pc + 1;
        lim = split_limit_reg > rie_pkg::MAX_TASKS ? rie_pkg::MAX_TASKS : split_limit_reg;
        case (pw.opcode)
          rie_pkg::I_MOV: begin
            s = peek(ea1);
            if (imm) begin
              d = peek(ea2);
              d.mode_b = s.mode_a;
              d.b_val = s.a_val;
            end else begin
              d = s;
            end
            d.owner = {1'b0, r.player};
            d.writer = 14'(pc);
            trial_mem[ea2] = d;
            trial_known[ea2] = 1'b1;
          end
          rie_pkg::I_ADD, rie_pkg::I_SUB: begin
            s = peek(ea1);
            d = peek(ea2);
            if (pw.opcode == rie_pkg::I_ADD) d.b_val = d.b_val + (imm ? s.a_val : s.b_val);
            else d.b_val = d.b_val - (imm ? s.a_val : s.b_val);
            d.owner = {1'b0, r.player};
            d.writer = 14'(pc);
            trial_mem[ea2] = d;
          end
          rie_pkg::I_JMP: nxt = ea1;
          rie_pkg::I_JMZ: begin
            d = peek(ea2);
            if (d.b_val == 16'd0) nxt = ea1;
          end
          rie_pkg::I_JMN: begin
            d = peek(ea2);
            if (d.b_val != 16'd0) nxt = ea1;
          end
          rie_pkg::I_DJN: begin
            d = peek(ea2);
            d.b_val = d.b_val - 16'd1;
            if (d.b_val != 16'd0) nxt = ea1;
            d.owner = {1'b0, r.player};
            d.writer = 14'(pc);
            trial_mem[ea2] = d;
          end
          rie_pkg::I_CMP: begin
            s = peek(ea1);
            d = peek(ea2);
            if (imm) same = s.a_val == d.b_val;
            else same = s.opcode == d.opcode && s.mode_a == d.mode_a &&
                        s.mode_b == d.mode_b && s.a_val == d.a_val && s.b_val == d.b_val;
            if (same) nxt = pc + 2;
          end
          rie_pkg::I_SPL: begin
            if (int'(r.task_count) < lim) begin
              rs.spawn_valid = 1'b1;
              rs.spawn_addr = 13'(ea2);
            end else begin
              rs.split_refused = 1'b1;
            end
          end
          default: begin
            // dat and unknown codes kill the task
            rs.task_died = 1'b1;
            return rs;
          end
        endcase
        rs.next_pc = 13'(wrap_addr(nxt));
      end
    endcase
    return rs;
  endfunction

  // run the item on a scratch copy; keep it only if it touches written words
  function automatic bit offer(req_t r);
    rie_pkg::result_t rs;
    trial_mem = core_mem;
    trial_known = core_known;
    touch_unknown = 1'b0;
    rs = predict_word(r);
    if (touch_unknown) return 1'b0;
    core_mem = trial_mem;
    core_known = trial_known;
    pend_q.push_back('{rq: r, rs: rs});
    n_op[r.op]++;
    n_spawn += rs.spawn_valid;
    n_refused += rs.split_refused;
    if (r.op == rie_pkg::OP_EXEC) n_died += rs.task_died;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [15:0] rand_value();
    if ($urandom_range(0, 99) < 80) return 16'($signed($urandom_range(0, 16)) - 8);
    return 16'($urandom);
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int lim;
    lim = split_limit_reg > rie_pkg::MAX_TASKS ? rie_pkg::MAX_TASKS : split_limit_reg;
    r.op = 2'($urandom_range(0, 3));
    r.address = 13'($urandom);
    r.player = 1'($urandom);
    // split decisions are most interesting right at the limit
    if ($urandom_range(0, 1) == 0) begin
      r.task_count = 7'(lim - 1 + $urandom_range(0, 2));
      if (r.task_count > 7'd64) r.task_count = 7'd64;
    end else begin
      r.task_count = 7'($urandom_range(0, 64));
    end
    if ($urandom_range(0, 99) < 85) r.opcode_in = 4'($urandom_range(0, 9));
    else r.opcode_in = 4'($urandom_range(10, 15));
    r.mode_a_in = 2'($urandom_range(0, 3));
    r.mode_b_in = 2'($urandom_range(0, 3));
    r.a_in = rand_value();
    r.b_in = rand_value();
    r.clear_writer = 14'($urandom_range(0, 8192));
    return r;
  endfunction

  // address inside the working window, now and then given above the core size
  function automatic logic [12:0] window_addr(int i);
    int sz, a;
    sz = size_eff();
    a = (region_base + i) % sz;
    if ($urandom_range(0, 5) == 0 && a + sz < rie_pkg::CORE_DEPTH) a += sz;
    return 13'(a);
  endfunction

  function automatic int window_span();
    return size_eff() < WINDOW ? size_eff() : WINDOW;
  endfunction

  task automatic fill_window();
    req_t r;
    for (int i = 0; i < window_span(); i++) begin
      r = rand_req();
      r.op = rie_pkg::OP_LOAD;
      r.address = window_addr(i);
      void'(offer(r));
    end
  endtask

  task automatic random_mix(int n);
    req_t r;
    int got, pick;
    got = 0;
    while (got < n) begin
      r = rand_req();
      pick = $urandom_range(0, 99);
      r.op = pick < 45 ? rie_pkg::OP_EXEC : pick < 65 ? rie_pkg::OP_LOAD :
             pick < 88 ? rie_pkg::OP_READ : rie_pkg::OP_CLEAR;
      if ($urandom_range(0, 9) != 0)
        r.address = window_addr($urandom_range(0, window_span() - 1));
      if (offer(r)) got++;
    end
  endtask

  // every opcode incl. unknown ones loaded, all but dat and code 12 executed; extreme operand values, reads and clears
  task automatic directed_words();
    logic [3:0] codes [12];
    req_t r;
    codes = '{rie_pkg::I_DAT, rie_pkg::I_MOV, rie_pkg::I_ADD, rie_pkg::I_SUB,
              rie_pkg::I_JMP, rie_pkg::I_JMZ, rie_pkg::I_JMN, rie_pkg::I_DJN,
              rie_pkg::I_CMP, rie_pkg::I_SPL, 4'd12, 4'd15};
    for (int i = 0; i < 12; i++) begin
      r = rand_req();
      r.op = rie_pkg::OP_LOAD;
      r.address = 13'(i);
      r.opcode_in = codes[i];
      r.mode_a_in = (i == 0 || i == 11) ? rie_pkg::M_IMM : 2'(i % 4);
      r.mode_b_in = (i == 0 || i == 11) ? rie_pkg::M_IMM : 2'((i / 4) % 4);
      r.a_in = i == 0 ? 16'h8000 : i == 11 ? 16'hffff : 16'((i % 3) - 1);
      r.b_in = i == 0 ? 16'h7fff : i == 11 ? 16'h0000 : 16'((i % 5) - 2);
      void'(offer(r));
    end
    for (int i = 1; i < 12; i++) begin
      if (i == 10) continue;
      r = rand_req();
      r.op = rie_pkg::OP_EXEC;
      r.address = 13'(i);
      r.task_count = i == 9 ? 7'd64 : 7'd0;
      void'(offer(r));
    end
    r = rand_req();
    r.op = rie_pkg::OP_READ;
    r.address = 13'd0;
    void'(offer(r));
    r.op = rie_pkg::OP_CLEAR;
    r.address = 13'd2;
    r.clear_writer = rie_pkg::LOADER_MARK;
    void'(offer(r));
    r.address = 13'd3;
    r.clear_writer = 14'd0;
    void'(offer(r));
    r.op = rie_pkg::OP_READ;
    r.address = 13'd2;
    void'(offer(r));
  endtask

  task automatic write_reg(logic [1:0] idx, int v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= 14'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == rie_pkg::CFG_CORE_SIZE) core_size_reg = v;
    else split_limit_reg = v;
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int sizes [N_PHASES];
    int limits [N_PHASES];
    sizes  = '{8000, 16, 1, 8192, 64, 37};
    limits = '{64, 1, 64, 33, 64, 5};
    rst_n <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= rie_pkg::CFG_CORE_SIZE;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // registers change only with nothing in flight
      if (ph > 0) begin
        wait_drained();
        write_reg(rie_pkg::CFG_CORE_SIZE, sizes[ph]);
        write_reg(rie_pkg::CFG_SPLIT_LIMIT, limits[ph]);
      end
      quiet = (ph == 2 || ph == 4);
      if (ph == 0) directed_words();
      region_base = $urandom_range(0, size_eff() - 1);
      fill_window();
      random_mix(RAND_PER_PHASE);
      // long receiver stall while the queue is full of requests
      if (ph == 1) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_q.size() != 0) err_count++;
    $display("covered %0d loads, %0d executes, %0d reads, %0d clears; %0d results checked",
             n_op[rie_pkg::OP_LOAD], n_op[rie_pkg::OP_EXEC], n_op[rie_pkg::OP_READ],
             n_op[rie_pkg::OP_CLEAR], n_results);
    $display("executes: %0d spawns, %0d refused splits, %0d task deaths; %0d mismatches",
             n_spawn, n_refused, n_died, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        result_q.push_back(pend_q[0].rs);
        pend_q.pop_front();
      end
      if (req_ch.valid && !req_ch.ready) begin
        // word still on offer, hold it
      end else if (send_wait > 0) begin
        req_ch.valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pend_q.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.op <= pend_q[0].rq.op;
        req_ch.address <= pend_q[0].rq.address;
        req_ch.player <= pend_q[0].rq.player;
        req_ch.task_count <= pend_q[0].rq.task_count;
        req_ch.opcode_in <= pend_q[0].rq.opcode_in;
        req_ch.mode_a_in <= pend_q[0].rq.mode_a_in;
        req_ch.mode_b_in <= pend_q[0].rq.mode_b_in;
        req_ch.a_in <= pend_q[0].rq.a_in;
        req_ch.b_in <= pend_q[0].rq.b_in;
        req_ch.clear_writer <= pend_q[0].rq.clear_writer;
        send_wait <= draw_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_go) hold_left <= HOLD_CYCLES;
  end

  always @(posedge clk) begin : monitor
    int w;
    rie_pkg::result_t want, got;
    w = recv_wait;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{next_pc: res_ch.next_pc, task_died: res_ch.task_died,
              spawn_valid: res_ch.spawn_valid, spawn_addr: res_ch.spawn_addr,
              split_refused: res_ch.split_refused,
              word: '{opcode: res_ch.word_opcode, mode_a: res_ch.word_mode_a,
                      mode_b: res_ch.word_mode_b, a_val: res_ch.word_a,
                      b_val: res_ch.word_b, owner: res_ch.word_owner,
                      writer: res_ch.word_writer}};
      n_results++;
      if (result_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result word %h", got);
      end else begin
        want = result_q.pop_front();
        if (got.next_pc !== want.next_pc || got.task_died !== want.task_died ||
            got.spawn_valid !== want.spawn_valid || got.spawn_addr !== want.spawn_addr ||
            got.split_refused !== want.split_refused ||
            got.word.opcode !== want.word.opcode || got.word.mode_a !== want.word.mode_a ||
            got.word.mode_b !== want.word.mode_b || got.word.a_val !== want.word.a_val ||
            got.word.b_val !== want.word.b_val || got.word.owner !== want.word.owner ||
            got.word.writer !== want.word.writer) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch #%0d: pc %0d/%0d died %b/%b spawn %b,%0d/%b,%0d ",
                      "refused %b/%b word %h/%h"}, n_results,
                     want.next_pc, got.next_pc, want.task_died, got.task_died,
                     want.spawn_valid, want.spawn_addr, got.spawn_valid, got.spawn_addr,
                     want.split_refused, got.split_refused, want.word, got.word);
        end
      end
      w = draw_gap();
    end
    if (!rst_n || hold_left != 0) begin
      res_ch.ready <= 1'b0;
    end else if (w > 0) begin
      res_ch.ready <= 1'b0;
      w--;
    end else begin
      res_ch.ready <= 1'b1;
    end
    recv_wait <= w;
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

FILE: redcode_instruction_executor.f
src/rie_pkg.sv
src/rie_if.sv
src/rie_wrap.sv
src/rie_core_mem.sv
src/redcode_instruction_executor.sv
tb/redcode_instruction_executor_test.sv
